FILE: sv/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants for the sensor polynomial calibration core.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int DATA_W       = 32;
    localparam int FRAC_W       = 16;
    localparam int COEF_REGS    = 6;
    localparam int COUNT_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int MAX_COEFS_DEF = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST  = 3'd6;

    typedef logic signed [DATA_W-1:0] q16_t;

    // Live configuration as seen by the Horner chain
    typedef struct packed {
        logic [COUNT_W-1:0]                    count_eff;
        logic [COEF_REGS-1:0][DATA_W-1:0]      coef;
    } spc_cfg_t;

endpackage

FILE: sv/spc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_cfg_regs
// Coefficient and count registers, with the count clamped to the usable range.
// ----------------------------------------------------------------------------
module spc_cfg_regs #(
    parameter int MAX_COEFS = spc_pkg::MAX_COEFS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spc_pkg::DATA_W-1:0]    cfg_data,
    output spc_pkg::spc_cfg_t             cfg
);
    import spc_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_COEFS);

    logic [COUNT_W-1:0]               count_reg;
    logic [COEF_REGS-1:0][DATA_W-1:0] coef_reg;
    logic [CFG_IDX_W-1:0]             coef_sel;

    assign cfg_ready = 1'b1;
    assign coef_sel  = CFG_IDX_W'(cfg_index - REG_COEF_FIRST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(1);
            coef_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Ignore writes beyond the last coefficient
            if (cfg_index == REG_COEF_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            else if (cfg_index >= REG_COEF_FIRST && cfg_index <= REG_COEF_LAST)
            begin
                coef_reg[coef_sel] <= cfg_data;
            end
        end
    end

    always_comb
    begin
        cfg.coef = coef_reg;
        priority if (count_reg == '0)
        begin
            cfg.count_eff = COUNT_W'(1);
        end
        else if (count_reg > COUNT_MAX)
        begin
            cfg.count_eff = COUNT_MAX;
        end
        else
        begin
            cfg.count_eff = count_reg;
        end
    end

endmodule

FILE: sv/spc_horner_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_horner_step
// One Horner step acc * x + coef in two register stages: a multiply stage,
// then rounding, coefficient add and saturation; inactive steps pass acc on.
// ----------------------------------------------------------------------------
module spc_horner_step #(
    parameter int STEP = 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [spc_pkg::COUNT_W-1:0] count_eff,
    input  spc_pkg::q16_t              coef,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  spc_pkg::q16_t              up_acc,
    input  spc_pkg::q16_t              up_x,
    input  logic                       up_ovf,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output spc_pkg::q16_t              dn_acc,
    output spc_pkg::q16_t              dn_x,
    output logic                       dn_ovf
);
    import spc_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int SCL_W  = PROD_W - FRAC_W;
    localparam logic [COUNT_W-1:0] STEP_IDX = COUNT_W'(STEP);
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(64'sd1 <<< (FRAC_W - 1));

    // Multiply stage
    logic                     a_valid_reg;
    logic signed [PROD_W-1:0] a_prod_reg;
    q16_t                     a_acc_reg;
    q16_t                     a_x_reg;
    logic                     a_ovf_reg;
    logic                     a_ready;

    // Add and saturate stage
    logic                     b_valid_reg;
    q16_t                     b_acc_reg;
    q16_t                     b_acc_next;
    q16_t                     b_x_reg;
    logic                     b_ovf_reg;
    logic                     b_ovf_next;
    logic                     b_ready;

    logic                     active;
    logic signed [PROD_W-1:0] rounded;
    logic signed [SCL_W-1:0]  scaled;
    logic signed [SCL_W:0]    sum;
    logic                     sat;

    assign active  = STEP_IDX < count_eff;
    assign b_ready = !b_valid_reg || dn_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign up_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_prod_reg <= PROD_W'(up_acc) * PROD_W'(up_x);
            a_acc_reg  <= up_acc;
            a_x_reg    <= up_x;
            a_ovf_reg  <= up_ovf;
        end
    end

    // Round half up, then drop the fraction bits of the product
    always_comb
    begin
        rounded = a_prod_reg + HALF_LSB;
        scaled  = rounded[PROD_W-1:FRAC_W];
        sum     = {scaled[SCL_W-1], scaled} + (SCL_W+1)'(coef);
        sat     = !((&sum[SCL_W:DATA_W-1]) || !(|sum[SCL_W:DATA_W-1]));
        if (!active)
        begin
            b_acc_next = a_acc_reg;
            b_ovf_next = a_ovf_reg;
        end
        else if (sat)
        begin
            b_acc_next = sum[SCL_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            b_ovf_next = 1'b1;
        end
        else
        begin
            b_acc_next = sum[DATA_W-1:0];
            b_ovf_next = a_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_acc_reg <= b_acc_next;
            b_x_reg   <= a_x_reg;
            b_ovf_reg <= b_ovf_next;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_acc   = b_acc_reg;
    assign dn_x     = b_x_reg;
    assign dn_ovf   = b_ovf_reg;

endmodule

FILE: sv/sensor_poly_calibration_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_poly_calibration_core
// Polynomial calibration of signed Q16.16 sensor samples by Horner's method.
// ----------------------------------------------------------------------------
// Each sample runs through a chain of MAX_COEFS-1 Horner steps, each step two
// register stages (32x32 multiply, then round, add coefficient and saturate).
// One sample is accepted per cycle unless a stalled output has filled the
// chain; every stage has its own valid bit and a stalled output only holds
// the stages that are full. Steps beyond the programmed coefficient count pass
// the value through untouched. Write configuration only while no sample is in
// flight; writes complete at once.
module sensor_poly_calibration_core #(
    parameter int MAX_COEFS = spc_pkg::MAX_COEFS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spc_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [spc_pkg::DATA_W-1:0] raw_sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [spc_pkg::DATA_W-1:0] calibrated_value,
    output logic                          overflow
);
    import spc_pkg::*;

    localparam int STEPS = MAX_COEFS - 1;

    spc_cfg_t cfg;

    logic [STEPS:0] chain_valid;
    logic [STEPS:0] chain_ready;
    q16_t           chain_acc [STEPS+1];
    q16_t           chain_x   [STEPS+1];
    logic [STEPS:0] chain_ovf;

    spc_cfg_regs #(
        .MAX_COEFS (MAX_COEFS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Seed the chain with the highest-order coefficient
    assign chain_valid[0] = sample_valid;
    assign sample_ready   = chain_ready[0];
    assign chain_acc[0]   = cfg.coef[0];
    assign chain_x[0]     = raw_sample;
    assign chain_ovf[0]   = 1'b0;

    for (genvar s = 1; s <= STEPS; s++)
    begin : g_step
        spc_horner_step #(
            .STEP (s)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .count_eff (cfg.count_eff),
            .coef      (cfg.coef[s]),
            .up_valid  (chain_valid[s-1]),
            .up_ready  (chain_ready[s-1]),
            .up_acc    (chain_acc[s-1]),
            .up_x      (chain_x[s-1]),
            .up_ovf    (chain_ovf[s-1]),
            .dn_valid  (chain_valid[s]),
            .dn_ready  (chain_ready[s]),
            .dn_acc    (chain_acc[s]),
            .dn_x      (chain_x[s]),
            .dn_ovf    (chain_ovf[s])
        );
    end

    assign result_valid       = chain_valid[STEPS];
    assign chain_ready[STEPS] = result_ready;
    assign calibrated_value   = chain_acc[STEPS];
    assign overflow           = chain_ovf[STEPS];

endmodule

FILE: tb/sensor_poly_calibration_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_poly_calibration_core_tb
// Self-checking bench for the Horner polynomial calibration core.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the coefficient registers and evaluates
// each accepted sample in 64-bit arithmetic with per-step saturation. Every
// result is checked in order against the oldest prediction. A directed part
// covers the extremes, a zero count, an oversized count, a single coefficient
// and a write to the spare register index. Randomised curves and samples then
// run under several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module sensor_poly_calibration_core_tb;

    import spc_pkg::*;

    localparam int MAX_TERMS   = MAX_COEFS_DEF;
    localparam int DRAIN_WAIT  = 2 * (MAX_TERMS - 1) + 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic signed [63:0] Q_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN  = -64'sd2147483648;
    localparam logic signed [63:0] Q_HALF = 64'sd32768;

    typedef struct packed {
        q16_t value;
        logic ovf;
    } calib_t;

    class calib_scoreboard;
        logic [COUNT_W-1:0] coef_count;
        q16_t               coef [COEF_REGS];
        calib_t             pending_calibs [$];
        int unsigned        failures;

        function new();
            coef_count = 3'd1;
            foreach (coef[i])
                coef[i] = '0;
            pending_calibs.delete();
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            if (idx == REG_COEF_COUNT)
                coef_count = data[COUNT_W-1:0];
            else if (idx >= REG_COEF_FIRST && idx <= REG_COEF_LAST)
                coef[idx - REG_COEF_FIRST] = data;
            // spare index: drop the write
        endfunction

        function calib_t horner_calibrate(q16_t x);
            logic signed [63:0] acc;
            logic signed [63:0] xs;
            logic signed [63:0] sum;
            int                 terms;
            calib_t             r;
            terms = coef_count;
            if (terms == 0)
                terms = 1;
            if (terms > MAX_TERMS)
                terms = MAX_TERMS;
            xs    = x;
            acc   = coef[0];
            r.ovf = 1'b0;
            for (int i = 1; i < terms; i++)
            begin
                // round half up: add half an LSB, then floor by arithmetic shift
                sum = ((acc * xs + Q_HALF) >>> FRAC_W) + coef[i];
                if (sum > Q_MAX)
                begin
                    sum   = Q_MAX;
                    r.ovf = 1'b1;
                end
                else if (sum < Q_MIN)
                begin
                    sum   = Q_MIN;
                    r.ovf = 1'b1;
                end
                acc = sum;
            end
            r.value = acc[DATA_W-1:0];
            return r;
        endfunction

        function void note_sample(q16_t x);
            pending_calibs.push_back(horner_calibrate(x));
        endfunction

        function void check_result(q16_t value, logic ovf);
            calib_t want;
            if (pending_calibs.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result: value %h overflow %0d", value, ovf);
            end
            else
            begin
                want = pending_calibs.pop_front();
                if (want.value !== value || want.ovf !== ovf)
                begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("mismatch: expected value %h overflow %0d, got value %h overflow %0d",
                                 want.value, want.ovf, value, ovf);
                end
            end
        endfunction

        function int pending();
            return pending_calibs.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 sample_valid;
    logic                 sample_ready;
    q16_t                 raw_sample;
    logic                 result_valid;
    logic                 result_ready;
    q16_t                 calibrated_value;
    logic                 overflow;

    calib_scoreboard sb;
    int              send_idle_pct;
    int              stall_pct;
    int unsigned     cycles;
    q16_t            curve [COEF_REGS];
    int              send_modes  [4] = '{0, 80, 0, 6};
    int              stall_modes [4] = '{0, 0, 80, 6};

    sensor_poly_calibration_core uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample_valid     (sample_valid),
        .sample_ready     (sample_ready),
        .raw_sample       (raw_sample),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .calibrated_value (calibrated_value),
        .overflow         (overflow)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // observe every handshake at the edge, before the driven values move on
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (sample_valid && sample_ready)
                sb.note_sample(raw_sample);
            if (result_valid && result_ready)
                sb.check_result(calibrated_value, overflow);
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_curve(input logic [DATA_W-1:0] count_word, input q16_t coefs [COEF_REGS]);
        cfg_write(REG_COEF_COUNT, count_word);
        for (int i = 0; i < COEF_REGS; i++)
            cfg_write(REG_COEF_FIRST + CFG_IDX_W'(i), coefs[i]);
        cfg_write(REG_SPARE, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input q16_t x);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        raw_sample   <= x;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    // hold until every prediction has been matched, then let the pipe settle
    task automatic finish_phase();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic q16_t pick_edge();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0001_0000;
            default: return 32'hFFFF_0000;
        endcase
    endfunction

    function automatic q16_t pick_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6)
            return q16_t'(int'($urandom_range(0, 393216)) - 196608);
        else if (kind < 9)
            return $urandom;
        else
            return pick_edge();
    endfunction

    function automatic q16_t pick_coef();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            return pick_edge();
        else if (kind < 3)
            return $urandom;
        else
            return q16_t'(int'($urandom_range(0, 524288)) - 262144);
    endfunction

    function automatic logic [DATA_W-1:0] pick_count_word();
        int          kind;
        logic [DATA_W-1:0] word;
        kind = $urandom_range(0, 9);
        word = $urandom & 32'hFFFF_FFF8;
        if (kind == 0)
            return word;
        else if (kind == 1)
            return word | 32'd7;
        else
            return word | $urandom_range(1, MAX_TERMS);
    endfunction

    initial
    begin
        sb            = new();
        cycles        = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        sample_valid  <= 1'b0;
        raw_sample    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset curve: constant zero
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        finish_phase();

        // x^2 + 0.5, unused coefficients left non-zero
        curve = '{32'h0001_0000, 32'h0000_0000, 32'h0000_8000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        load_curve(32'd3, curve);
        send_sample(32'h0000_0000);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_0000);
        send_sample(32'h0000_0001);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        finish_phase();

        // zero count behaves as a single coefficient
        curve = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        load_curve(32'd0, curve);
        send_sample(32'h1234_5678);
        send_sample(32'h8000_0000);
        finish_phase();

        // oversized count clips to the full chain; upper data bits ignored
        curve = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        load_curve(32'hFFFF_FFFF, curve);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_0000);
        send_sample(32'h0000_8000);
        send_sample(32'h7FFF_FFFF);
        finish_phase();

        // full-degree curve with modest coefficients to exercise rounding
        curve = '{32'h0000_8000, 32'hFFFF_0000, 32'h0002_0000,
                  32'h0000_4000, 32'hFFFD_0000, 32'h0001_8000};
        load_curve(32'd6, curve);
        send_sample(32'h0000_8000);
        send_sample(32'hFFFE_8000);
        send_sample(32'h0000_0001);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        finish_phase();

        // single coefficient passes straight through
        curve = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        load_curve(32'd1, curve);
        send_sample(32'h8000_0000);
        finish_phase();

        for (int mode = 0; mode < 4; mode++)
        begin
            send_idle_pct = send_modes[mode];
            stall_pct     = stall_modes[mode];
            for (int p = 0; p < 3; p++)
            begin
                foreach (curve[i])
                    curve[i] = pick_coef();
                load_curve(pick_count_word(), curve);
                repeat (54) send_sample(pick_sample());
                finish_phase();
            end
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
sv/spc_pkg.sv
sv/spc_cfg_regs.sv
sv/spc_horner_step.sv
sv/sensor_poly_calibration_core.sv
tb/sensor_poly_calibration_core_tb.sv
